/* hw/rtl/pip_pkg.sv */
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W = 16;
    localparam int VC_W    = 5;
    localparam int PADDR_W = 2;
    localparam int DATA_W  = 32;
    localparam int DVD_W   = 32;
    localparam int DSR_W   = 16;

    localparam logic [VC_W-1:0] VC_RESET = 5'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic [3:0]                vertex_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic                      last_point;
    } pip_req_t;

    typedef struct packed {
        logic point_inside;
        logic any_inside;
        logic run_end;
    } pip_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LATCH,
        ST_EDGE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CMP,
        ST_DONE
    } pip_state_t;

endpackage

/* hw/rtl/pip_mem.sv */
// ----------------------------------------------------------------------------
// pip_mem
// Fence vertex memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pip_mem
    import pip_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [2*COORD_W-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [2*COORD_W-1:0]         rdata
);

    logic [2*COORD_W-1:0] mem [DEPTH];
    logic [2*COORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/pip_div.sv */
// ----------------------------------------------------------------------------
// pip_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pip_div
    import pip_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   rem_sh;
    logic [DSR_W+1:0] diff;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dsr_reg};
        if (start)
        begin
            cnt_next = CNT_W'(DVD_W);
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[DSR_W+1])
            begin
                rem_next = diff[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/point_in_polygon_crossing_test.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Crossing-number test of a point against a stored fence polygon.
// A load request writes one vertex when accepted; a test request fetches and latches
//   each of the edges in use and runs the divider for each crossing edge that is not vertical.
// One test at a time: no new request is accepted until the current test has issued its result.
// Reset: vertex_count returns to 3, run flag clears; fence memory is not reset.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               req_valid,
    output logic               req_ready,
    input  pip_req_t           req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pip_rsp_t           rsp
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    pip_state_t                state_reg, state_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [COORD_W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic                      last_reg, last_next;
    logic                      odd_reg, odd_next;
    logic signed [33:0]        prod_reg, prod_next;
    logic signed [16:0]        den_reg, den_next;
    logic                      run_hit_reg, run_hit_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    pip_rsp_t                  rsp_reg, rsp_next;
    logic [VC_W-1:0]           vc_reg;

    logic [CW-1:0]             n_use;
    logic [CW-1:0]             k_idx;
    logic                      mem_we;
    logic [2*COORD_W-1:0]      mem_rdata;
    logic                      div_start;
    logic                      div_done;
    logic [DVD_W-1:0]          div_quo;
    logic [DVD_W-1:0]          dvd_mag;
    logic [DSR_W-1:0]          dsr_mag;
    logic signed [16:0]        dy_p, dx_e, dy_e;
    logic signed [33:0]        prod_abs, q_s, xi;
    logic signed [16:0]        den_abs;
    logic signed [COORD_W-1:0] ylo, yhi, xhi;
    logic                      hit_cond;
    logic                      adv;
    logic                      any_hit;

    // ---- configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VC_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            vc_reg <= pwdata[VC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = DATA_W'(vc_reg);

    always_comb
    begin
        if (vc_reg == '0)
        begin
            n_use = CW'(1);
        end
        else if (int'(vc_reg) > MAX_VERTICES)
        begin
            n_use = CW'(MAX_VERTICES);
        end
        else
        begin
            n_use = CW'(vc_reg);
        end
    end

    assign k_idx = (idx_reg == n_use) ? '0 : idx_reg;

    // ---- fence memory and divider
    assign req_ready = (state_reg == ST_IDLE);
    assign mem_we    = req_valid && req_ready && (req.operation == OP_LOAD)
                       && (int'(req.vertex_index) < MAX_VERTICES);

    pip_mem #(
        .DEPTH (MAX_VERTICES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(req.vertex_index)),
        .wdata ({req.coord_x, req.coord_y}),
        .raddr (AW'(k_idx)),
        .rdata (mem_rdata)
    );

    assign prod_abs = prod_reg[33] ? -prod_reg : prod_reg;
    assign den_abs  = den_reg[16] ? -den_reg : den_reg;
    assign dvd_mag  = prod_abs[DVD_W-1:0];
    assign dsr_mag  = den_abs[DSR_W-1:0];

    pip_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_mag),
        .divisor  (dsr_mag),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---- edge arithmetic
    assign dy_p = 17'(py_reg) - 17'(ay_reg);
    assign dx_e = 17'(bx_reg) - 17'(ax_reg);
    assign dy_e = 17'(by_reg) - 17'(ay_reg);
    assign ylo  = (ay_reg < by_reg) ? ay_reg : by_reg;
    assign yhi  = (ay_reg > by_reg) ? ay_reg : by_reg;
    assign xhi  = (ax_reg > bx_reg) ? ax_reg : bx_reg;
    assign hit_cond = (py_reg > ylo) && (py_reg <= yhi) && (px_reg <= xhi)
                      && (ay_reg != by_reg);

    assign q_s = (prod_reg[33] ^ den_reg[16]) ? -$signed({2'b00, div_quo})
                                               : $signed({2'b00, div_quo});
    assign xi  = q_s + 34'(ax_reg);

    assign any_hit = run_hit_reg || odd_reg;

    // ---- sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        last_next      = last_reg;
        odd_next       = odd_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        run_hit_next   = run_hit_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        div_start      = 1'b0;
        adv            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (req.operation == OP_TEST))
                begin
                    px_next    = req.coord_x;
                    py_next    = req.coord_y;
                    last_next  = req.last_point;
                    idx_next   = '0;
                    odd_next   = 1'b0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                if (idx_reg == '0)
                begin
                    ax_next    = mem_rdata[2*COORD_W-1:COORD_W];
                    ay_next    = mem_rdata[COORD_W-1:0];
                    idx_next   = CW'(1);
                    state_next = ST_FETCH;
                end
                else
                begin
                    bx_next    = mem_rdata[2*COORD_W-1:COORD_W];
                    by_next    = mem_rdata[COORD_W-1:0];
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                prod_next = dy_p * dx_e;
                den_next  = dy_e;
                if (hit_cond && (ax_reg != bx_reg))
                begin
                    state_next = ST_DIV_START;
                end
                else
                begin
                    odd_next = odd_reg ^ hit_cond;
                    adv      = 1'b1;
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                odd_next = odd_reg ^ (34'(px_reg) <= xi);
                adv      = 1'b1;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.point_inside = odd_reg;
                    rsp_next.any_inside   = any_hit;
                    rsp_next.run_end      = last_reg;
                    rsp_valid_next        = 1'b1;
                    run_hit_next          = last_reg ? 1'b0 : any_hit;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // advance to the next edge, or to ST_DONE after the last one
        if (adv)
        begin
            ax_next = bx_reg;
            ay_next = by_reg;
            if (idx_reg == n_use)
            begin
                state_next = ST_DONE;
            end
            else
            begin
                idx_next   = CW'(idx_reg + 1'b1);
                state_next = ST_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_hit_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_hit_reg   <= run_hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        last_reg <= last_next;
        odd_reg  <= odd_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* hw/rtl/pip_chk.sv */
// ----------------------------------------------------------------------------
// pip_chk
// Port-level checks of the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
module pip_chk
    import pip_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input pip_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input pip_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    a_busy_after_test: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.operation == OP_TEST) |=> !req_ready)
        else $error("test request did not make the block busy");

    a_any_covers_point: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.point_inside |-> rsp.any_inside)
        else $error("run flag misses an inside point");

    a_load_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.operation == OP_LOAD) && !rsp_valid
        |=> !rsp_valid)
        else $error("load request produced a response");

endmodule

bind point_in_polygon_crossing_test pip_chk u_pip_chk (.*);

/* bench/pip_crossing_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pip_crossing_checker
// Watches the request, result and register channels of the point-in-polygon
// block, keeps its own fence polygon, vertex count and run flag, works out the
// crossing parity of every test request and compares each result in order.
// ----------------------------------------------------------------------------
module pip_crossing_checker
    import pip_pkg::*;
#(
    parameter int                 MAX_VERTICES = 16,
    parameter logic [PADDR_W-1:0] VC_ADDR      = '0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               pready,
    input  logic               req_valid,
    input  logic               req_ready,
    input  pip_req_t           req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  pip_rsp_t           rsp,
    output int                 mismatches,
    output int                 verdicts_owed
);

    longint          fence_x [MAX_VERTICES];
    longint          fence_y [MAX_VERTICES];
    logic [VC_W-1:0] vertex_count_copy;
    logic            run_hit;
    pip_rsp_t        pending_verdicts [$];
    pip_rsp_t        want;
    int              mismatch_total = 0;

    function automatic logic crossing_parity(input longint px, input longint py);
        int     n;
        int     i;
        int     k;
        logic   odd;
        longint ax;
        longint ay;
        longint bx;
        longint by;
        longint ylo;
        longint yhi;
        longint xhi;
        longint num;
        longint xi;
        n = vertex_count_copy;
        if (n == 0)
            n = 1;
        if (n > MAX_VERTICES)
            n = MAX_VERTICES;
        odd = 1'b0;
        ax  = fence_x[0];
        ay  = fence_y[0];
        for (i = 1; i <= n; i++)
        begin
            k   = (i == n) ? 0 : i;
            bx  = fence_x[k];
            by  = fence_y[k];
            ylo = (ay < by) ? ay : by;
            yhi = (ay > by) ? ay : by;
            xhi = (ax > bx) ? ax : bx;
            if (py > ylo && py <= yhi && px <= xhi && ay != by)
            begin
                num = (py - ay) * (bx - ax);
                xi  = num / (by - ay) + ax;
                if (ax == bx || px <= xi)
                    odd = ~odd;
            end
            ax = bx;
            ay = by;
        end
        return odd;
    endfunction

    function automatic int field_mismatch(input string name, input logic expv,
                                          input logic actv);
        if (actv === expv)
            return 0;
        $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, expv, actv);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_copy = VC_RESET;
            run_hit           = 1'b0;
            pending_verdicts.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == VC_ADDR)
                vertex_count_copy = pwdata[VC_W-1:0];
            if (rsp_valid && rsp_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: result %b arrived, expected none", $time, rsp);
                    mismatch_total++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    mismatch_total += field_mismatch("point_inside", want.point_inside,
                                                     rsp.point_inside);
                    mismatch_total += field_mismatch("any_inside", want.any_inside,
                                                     rsp.any_inside);
                    mismatch_total += field_mismatch("run_end", want.run_end,
                                                     rsp.run_end);
                end
            end
            if (req_valid && req_ready)
            begin
                if (req.operation == OP_LOAD)
                begin
                    if (req.vertex_index < MAX_VERTICES)
                    begin
                        fence_x[req.vertex_index] = longint'($signed(req.coord_x));
                        fence_y[req.vertex_index] = longint'($signed(req.coord_y));
                    end
                end
                else
                begin
                    want.point_inside = crossing_parity(longint'($signed(req.coord_x)),
                                                        longint'($signed(req.coord_y)));
                    want.any_inside   = run_hit | want.point_inside;
                    want.run_end      = req.last_point;
                    run_hit           = req.last_point ? 1'b0 : want.any_inside;
                    pending_verdicts.push_back(want);
                end
            end
        end
        mismatches    <= mismatch_total;
        verdicts_owed <= pending_verdicts.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the point-in-polygon crossing test. Loads a fence
// polygon, walks through directed corner points and vertex counts, then runs
// phases of random loads and test runs under varied sender and receiver idling,
// including a long receiver hold-off, while the checker compares every result.
// ----------------------------------------------------------------------------
module tb;
    import pip_pkg::*;

    localparam int                 MAX_VERTICES      = 16;
    localparam logic [PADDR_W-1:0] VERTEX_COUNT_ADDR = '0;
    localparam int                 IDLE_HEAVY        = 65;
    localparam int                 IDLE_LIGHT        = 13;
    localparam int                 LONG_HOLD         = 3000;
    localparam int                 SETTLE_CYCLES     = 8;
    localparam int                 WATCHDOG_LIMIT    = 20000;
    localparam int                 PHASE_COUNT       = 8;
    localparam int                 PHASE_REQUESTS    = 75;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               req_valid;
    logic               req_ready;
    pip_req_t           req;
    logic               rsp_valid;
    logic               rsp_ready;
    pip_rsp_t           rsp;

    int mismatches;
    int verdicts_owed;
    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int hold_cycles_req = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    point_in_polygon_crossing_test #(
        .MAX_VERTICES(MAX_VERTICES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    pip_crossing_checker #(
        .MAX_VERTICES(MAX_VERTICES),
        .VC_ADDR     (VERTEX_COUNT_ADDR)
    ) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .mismatches   (mismatches),
        .verdicts_owed(verdicts_owed)
    );

    // hold off results for a long stretch on request, else stall at random
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_req != 0)
            begin
                hold_left       = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("point_in_polygon_crossing_test test failed");
        $finish;
    end

    function automatic logic signed [COORD_W-1:0] pick_coord();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0)
        begin
            case ($urandom_range(3))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return '0;
                default: return '1;
            endcase
        end
        else if (sel < 4)
            return COORD_W'(int'($urandom_range(127)) - 64);
        return COORD_W'($urandom);
    endfunction

    task automatic send_request(input logic op, input logic [3:0] idx,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y, input logic last);
        pip_req_t r;
        r.operation    = op;
        r.vertex_index = idx;
        r.coord_x      = x;
        r.coord_y      = y;
        r.last_point   = last;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic load_vertex(input logic [3:0] idx, input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        send_request(OP_LOAD, idx, x, y, 1'b0);
    endtask

    task automatic test_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input logic last);
        send_request(OP_TEST, 4'($urandom_range(15)), x, y, last);
    endtask

    // drop valid and wait for every result to come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VERTEX_COUNT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int   sent;
        int   run_len;
        int   j;
        logic closed;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(4) == 0)
            begin
                load_vertex(4'($urandom_range(15)), pick_coord(), pick_coord());
                sent++;
            end
            else
            begin
                run_len = $urandom_range(1, 6);
                closed  = ($urandom_range(9) != 0);
                for (j = 0; j < run_len; j++)
                    test_point(pick_coord(), pick_coord(), closed && j == run_len - 1);
                sent += run_len;
            end
        end
    endtask

    initial
    begin
        int i;
        int p;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        req       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_vertex(4'd0, 16'sh8000, 16'sh8000);
        load_vertex(4'd1, 16'sh7fff, 16'sh8000);
        load_vertex(4'd2, 16'sh7fff, 16'sh7fff);
        for (i = 3; i < MAX_VERTICES; i++)
            load_vertex(4'(i), COORD_W'(i * 4000 - 32000),
                        COORD_W'((i % 2) ? 30000 - i * 1000 : i * 1000 - 30000));
        test_point(0, 0, 1'b0);
        test_point(100, -100, 1'b0);
        test_point(-100, 100, 1'b0);
        test_point(16'sh7fff, 16'sh7fff, 1'b0);
        test_point(16'sh8000, 16'sh8000, 1'b0);
        test_point(16'sh7fff, 16'sh8001, 1'b1);
        wait_drained();
        write_vertex_count(0);
        test_point(5, 5, 1'b0);
        test_point(16'sh8000, 16'sh7fff, 1'b1);
        wait_drained();
        write_vertex_count(31);
        test_point(0, 0, 1'b0);
        test_point(-1, -1, 1'b1);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            case (p)
                0:       write_vertex_count(3);
                1:       write_vertex_count(16);
                2:       write_vertex_count(1);
                3:       write_vertex_count(31);
                4:       write_vertex_count(5);
                5:       write_vertex_count(0);
                6:       write_vertex_count(17);
                default: write_vertex_count($urandom_range(2, 15));
            endcase
            case (p % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = IDLE_HEAVY;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = IDLE_HEAVY;
                end
                default:
                begin
                    tx_idle_pct  = IDLE_LIGHT;
                    rx_stall_pct = IDLE_LIGHT;
                end
            endcase
            if (p == 4)
                hold_cycles_req = LONG_HOLD;
            random_traffic(PHASE_REQUESTS);
        end
        wait_drained();

        if (mismatches == 0)
            $display("point_in_polygon_crossing_test test passed");
        else
            $display("point_in_polygon_crossing_test test failed");
        $finish;
    end

endmodule
